[sv/assert_macros.svh]
// Assertion macros shared by the address generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, off during reset
`define TPAG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, clocked on clk, off during reset
`define TPAG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TPAG_ASSERT_IMPL(lbl, ante, cons, msg)
`define TPAG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/tpag_pkg.sv]
// Shared types and constants for the tensor permute address generator.
`default_nettype none

package tpag_pkg;

    localparam int ADDR_W        = 48;
    localparam int DIG_W         = 16;
    localparam int SIZE_REG_W    = 16;
    localparam int NUM_SIZE_REGS = 4;
    localparam int AXIS_W        = 8;
    localparam int ELEM_W        = 5;
    localparam int CFG_IDX_W     = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM0 = 3'd0,
        CFG_DIM1 = 3'd1,
        CFG_DIM2 = 3'd2,
        CFG_DIM3 = 3'd3,
        CFG_AXIS = 3'd4,
        CFG_ELEM = 3'd5,
        CFG_SRC  = 3'd6,
        CFG_DST  = 3'd7
    } cfg_idx_t;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic en;
        logic accum;
    } mac_ctl_t;

endpackage

`default_nettype wire

[sv/tensor_permute_address_gen_unit.sv]
// Top level of the N-dimensional tensor permute address generator.
//
//   channel   direction   handshake              payload
//   request   in          in_valid / in_stall    restart
//   result    out         out_valid / out_stall  src_addr, dst_addr, last
//   config    in          cfg_we                 cfg_index, cfg_data
//
// Each request runs through the single shared 48x16 multiply-accumulate in
// order: strides first, then the index dot product, then scaling by the
// element size for each address.
// in_stall is high from acceptance until the result is loaded into the output
// register; a stalled output holds the sequencer in its final step.
// Reset clears the counters and loads the register defaults.
`default_nettype none

`include "assert_macros.svh"

module tensor_permute_address_gen_unit #(
    parameter int MAX_DIMS = 4,
    parameter int DIM_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tpag_pkg::ADDR_W-1:0]       src_addr,
    output logic [tpag_pkg::ADDR_W-1:0]       dst_addr,
    output logic                              last,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [tpag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpag_pkg::ADDR_W-1:0]       cfg_data
);
    import tpag_pkg::*;

    localparam int DIM_IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W  = $clog2(MAX_DIMS + 1);
    localparam int NDIG   = (DIM_BITS + DIG_W - 1) / DIG_W;
    localparam int DIG_IW = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int IDXX_W = NDIG * DIG_W;
    localparam int SZ_W   = (DIM_BITS < SIZE_REG_W) ? DIM_BITS : SIZE_REG_W;
    localparam int NXT_W  = DIM_BITS + 1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_STRIDE = 6'b000010,
        ST_DOT    = 6'b000100,
        ST_SRC    = 6'b001000,
        ST_DST    = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    // Configuration registers
    logic [SIZE_REG_W-1:0] dim_size_reg [NUM_SIZE_REGS];
    logic [AXIS_W-1:0]     axis_order_reg;
    logic [ELEM_W-1:0]     elem_bytes_reg;
    logic [ADDR_W-1:0]     src_base_reg;
    logic [ADDR_W-1:0]     dst_base_reg;

    // Sequencer and counters
    state_t                state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIM_IW-1:0]     dot_reg;
    logic [DIG_IW-1:0]     dig_reg;
    logic [DIM_BITS-1:0]   dst_index_reg [MAX_DIMS];
    logic [ADDR_W-1:0]     dst_count_reg;

    // Datapath storage
    logic [ADDR_W-1:0]     stride_reg [MAX_DIMS];
    logic [ADDR_W-1:0]     src_hold_reg;
    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     src_addr_reg;
    logic [ADDR_W-1:0]     dst_addr_reg;
    logic                  last_reg;

    // Derived values
    logic [SZ_W-1:0]       src_size [MAX_DIMS];
    logic [DIM_IW-1:0]     axis_of [MAX_DIMS];
    logic [SZ_W-1:0]       extent [MAX_DIMS];
    logic [NXT_W-1:0]      idx_inc [MAX_DIMS];
    logic [DIM_BITS-1:0]   idx_next [MAX_DIMS];
    logic [MAX_DIMS-1:0]   wrap;
    logic [MAX_DIMS-1:0]   carry_in;
    logic                  odo_last;
    logic [DIM_IW-1:0]     str_idx;
    logic [IDXX_W-1:0]     idx_ext;

    // Handshake
    logic                  accept;
    logic                  out_free;
    logic                  load;

    // Shared unit
    mac_ctl_t              mac_ctl;
    logic [ADDR_W-1:0]     mac_a;
    logic [DIG_W-1:0]      mac_b;
    logic [ADDR_W-1:0]     mac_addend;
    logic [ADDR_W-1:0]     mac_acc;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_SIZE_REGS; d++)
            begin
                dim_size_reg[d] <= SIZE_REG_W'(1);
            end
            axis_order_reg <= AXIS_W'(228);
            elem_bytes_reg <= ELEM_W'(1);
            src_base_reg   <= '0;
            dst_base_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIM0, CFG_DIM1, CFG_DIM2, CFG_DIM3:
                    dim_size_reg[cfg_index[1:0]] <= cfg_data[SIZE_REG_W-1:0];
                CFG_AXIS: axis_order_reg <= cfg_data[AXIS_W-1:0];
                CFG_ELEM: elem_bytes_reg <= cfg_data[ELEM_W-1:0];
                CFG_SRC:  src_base_reg   <= cfg_data;
                CFG_DST:  dst_base_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Source sizes (zero reads as one) and axis map per lane
    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_lane
        if (d < NUM_SIZE_REGS)
        begin : g_reg
            assign src_size[d] = (dim_size_reg[d][SZ_W-1:0] == '0) ? SZ_W'(1)
                                                                : dim_size_reg[d][SZ_W-1:0];
            assign axis_of[d]  = DIM_IW'(32'(axis_order_reg[2*d +: 2]) % MAX_DIMS);
        end
        else
        begin : g_fixed
            assign src_size[d] = SZ_W'(1);
            assign axis_of[d]  = DIM_IW'(d);
        end
    end

    // Odometer: each lane wraps at its extent, carries ripple from the innermost
    for (genvar i = 0; i < MAX_DIMS; i++)
    begin : g_odo
        assign extent[i]  = src_size[axis_of[i]];
        assign idx_inc[i] = NXT_W'(dst_index_reg[i]) + NXT_W'(1);
        assign wrap[i]    = (idx_inc[i] >= NXT_W'(extent[i]));
        if (i == MAX_DIMS - 1)
        begin : g_inner
            assign carry_in[i] = 1'b1;
        end
        else
        begin : g_outer
            assign carry_in[i] = carry_in[i+1] & wrap[i+1];
        end
        assign idx_next[i] = !carry_in[i] ? dst_index_reg[i]
                           : (wrap[i] ? '0 : idx_inc[i][DIM_BITS-1:0]);
    end

    assign odo_last = carry_in[0] & wrap[0];

    // Handshake
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign load     = (state_reg == ST_DONE) && out_free;

    // Stride slot handled by this step; index digit for the dot product
    assign str_idx = DIM_IW'(CNT_W'(MAX_DIMS) - cnt_reg);
    assign idx_ext = IDXX_W'(dst_index_reg[dot_reg]);

    // Operand selection for the shared unit
    always_comb
    begin
        mac_ctl    = '0;
        mac_a      = '0;
        mac_b      = '0;
        mac_addend = '0;
        unique case (state_reg)
            ST_STRIDE:
            begin
                // innermost stride is one, each outer one is the next times its size
                mac_ctl.en = (cnt_reg != CNT_W'(MAX_DIMS));
                if (cnt_reg == '0)
                begin
                    mac_a = ADDR_W'(1);
                    mac_b = DIG_W'(1);
                end
                else
                begin
                    mac_a = mac_acc;
                    mac_b = DIG_W'(src_size[str_idx]);
                end
            end
            ST_DOT:
            begin
                mac_ctl.en    = 1'b1;
                mac_ctl.accum = (dot_reg != '0) || (dig_reg != '0);
                mac_a         = stride_reg[axis_of[dot_reg]] << (DIG_W * dig_reg);
                mac_b         = idx_ext[dig_reg*DIG_W +: DIG_W];
            end
            ST_SRC:
            begin
                mac_ctl.en = 1'b1;
                mac_a      = mac_acc;
                mac_b      = DIG_W'(elem_bytes_reg);
                mac_addend = src_base_reg;
            end
            ST_DST:
            begin
                mac_ctl.en = 1'b1;
                mac_a      = dst_count_reg;
                mac_b      = DIG_W'(elem_bytes_reg);
                mac_addend = dst_base_reg;
            end
            default: ;
        endcase
    end

    tpag_mac u_mac (
        .clk    (clk),
        .ctl    (mac_ctl),
        .a      (mac_a),
        .b      (mac_b),
        .addend (mac_addend),
        .acc    (mac_acc)
    );

    // Sequencer, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            dot_reg       <= '0;
            dig_reg       <= '0;
            dst_count_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                dst_index_reg[i] <= '0;
            end
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_STRIDE;
                        cnt_reg   <= '0;
                        if (restart)
                        begin
                            dst_count_reg <= '0;
                            for (int i = 0; i < MAX_DIMS; i++)
                            begin
                                dst_index_reg[i] <= '0;
                            end
                        end
                    end
                end
                ST_STRIDE:
                begin
                    if (cnt_reg == CNT_W'(MAX_DIMS))
                    begin
                        state_reg <= ST_DOT;
                        dot_reg   <= '0;
                        dig_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_DOT:
                begin
                    if (dig_reg == DIG_IW'(NDIG - 1))
                    begin
                        dig_reg <= '0;
                        if (dot_reg == DIM_IW'(MAX_DIMS - 1))
                        begin
                            state_reg <= ST_SRC;
                        end
                        else
                        begin
                            dot_reg <= dot_reg + DIM_IW'(1);
                        end
                    end
                    else
                    begin
                        dig_reg <= dig_reg + DIG_IW'(1);
                    end
                end
                ST_SRC:
                begin
                    state_reg <= ST_DST;
                end
                ST_DST:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // advance only when the result register takes this request
                    if (out_free)
                    begin
                        state_reg     <= ST_IDLE;
                        dst_count_reg <= odo_last ? '0 : dst_count_reg + ADDR_W'(1);
                        for (int i = 0; i < MAX_DIMS; i++)
                        begin
                            dst_index_reg[i] <= idx_next[i];
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Stride store, source address hold and result register
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_STRIDE) && (cnt_reg != '0))
        begin
            stride_reg[str_idx] <= mac_acc;
        end
        if (state_reg == ST_DST)
        begin
            src_hold_reg <= mac_acc;
        end
        if (load)
        begin
            src_addr_reg <= src_hold_reg;
            dst_addr_reg <= mac_acc;
            last_reg     <= odo_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign src_addr  = src_addr_reg;
    assign dst_addr  = dst_addr_reg;
    assign last      = last_reg;

    // Checks
    `TPAG_ASSERT_NEXT(a_accept_starts, accept, (state_reg == ST_STRIDE), "request did not start")
    `TPAG_ASSERT_IMPL(a_out_done, $rose(out_valid), ($past(state_reg) == ST_DONE), "stray result")
    `TPAG_ASSERT_NEXT(a_wrap_count, (load && odo_last), (dst_count_reg == '0), "count not cleared")
    `TPAG_ASSERT_NEXT(a_count_holds, (!load && !accept), $stable(dst_count_reg), "count moved")

endmodule

`default_nettype wire

[sv/tpag_mac.sv]
// Shared 48x16 multiply-accumulate unit with a registered result.
`default_nettype none

module tpag_mac (
    input  logic                          clk,
    input  tpag_pkg::mac_ctl_t            ctl,
    input  logic [tpag_pkg::ADDR_W-1:0]   a,
    input  logic [tpag_pkg::DIG_W-1:0]    b,
    input  logic [tpag_pkg::ADDR_W-1:0]   addend,
    output logic [tpag_pkg::ADDR_W-1:0]   acc
);
    import tpag_pkg::*;

    localparam int PROD_W = ADDR_W + DIG_W;

    logic [PROD_W-1:0] prod;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] acc_reg;
    logic [ADDR_W-1:0] acc_next;

    // Product kept modulo 2^48, added to either the running sum or the addend
    assign prod     = PROD_W'(a) * PROD_W'(b);
    assign base     = ctl.accum ? acc_reg : addend;
    assign acc_next = base + prod[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire
